// ===== rtl/core/arh_pkg.sv =====
`timescale 1ns / 1ps

package arh_pkg;

  // Fixed field widths
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned ENTRY_IDX_W    = 10;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned HIT_CLASS_W    = 2;
  localparam int unsigned HIT_INDEX_W    = 10;
  localparam int unsigned COUNT_W        = 32;

  // Stream payload packing, padded to whole bytes
  localparam int unsigned IN_TDATA_W     = 80;
  localparam int unsigned OUT_TDATA_W    = 48;

  // Configuration port
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 11;
  localparam int unsigned FINE_USED_W    = 11;
  localparam int unsigned COARSE_USED_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_FINE_USED   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COARSE_USED = 2'd1;

  // Default table depths
  localparam int unsigned FINE_DEPTH_DEF   = 1024;
  localparam int unsigned COARSE_DEPTH_DEF = 256;

  typedef enum logic [KIND_W-1:0] {
    KIND_FINE   = 2'd0,
    KIND_COARSE = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_e;

  typedef enum logic [HIT_CLASS_W-1:0] {
    CLS_FINE   = 2'd0,
    CLS_COARSE = 2'd1,
    CLS_UNDEF  = 2'd2
  } hit_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FPROBE,
    ST_FCHECK,
    ST_CSCAN,
    ST_OUT
  } state_e;

  // Requests from the sequencer to one range table
  typedef struct packed {
    logic load;   // write start/length, clear counter
    logic rd;     // read entry at rd index
    logic bump;   // write back incremented counter
  } tbl_req_t;

endpackage

// ===== rtl/core/address_range_hit_profiler.sv =====
`timescale 1ns / 1ps
// A load or unused-kind item is taken in ST_IDLE and gives no result; loads go back to back.
// A sample runs a binary search of the fine table, an ST_FPROBE and an ST_FCHECK per probe
// (at most log2(fine entries)+1 probes), then on a miss scans the coarse table entry by entry
// in ST_CSCAN, and waits in ST_OUT until the output register takes the result. A new item is
// accepted only back in ST_IDLE. Reset clears the sequencer, the counts and the undefined
// counter; tables are not cleared, a loaded entry's counter starts at zero.
module address_range_hit_profiler #(
  parameter int unsigned FINE_DEPTH   = arh_pkg::FINE_DEPTH_DEF,
  parameter int unsigned COARSE_DEPTH = arh_pkg::COARSE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] entry_index, [41:10] address, [73:42] range_length, [79:74] zero
  input  logic [arh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] kind
  input  logic [arh_pkg::KIND_W-1:0]        s_axis_tuser,
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] hit_index, [41:10] hit_total, [47:42] zero
  output logic [arh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] hit_class
  output logic [arh_pkg::HIT_CLASS_W-1:0]   m_axis_tuser,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [arh_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [arh_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import arh_pkg::*;

  localparam int unsigned FIW = (FINE_DEPTH > 1) ? $clog2(FINE_DEPTH) : 1;
  localparam int unsigned FCW = $clog2(FINE_DEPTH + 1);
  localparam int unsigned CIW = (COARSE_DEPTH > 1) ? $clog2(COARSE_DEPTH) : 1;
  localparam int unsigned CCW = $clog2(COARSE_DEPTH + 1);

  // Input fields
  logic [KIND_W-1:0]      in_kind;
  logic [ENTRY_IDX_W-1:0] in_entry_index;
  logic [ADDR_W-1:0]      in_address;
  logic [ADDR_W-1:0]      in_range_length;

  assign in_kind         = s_axis_tuser;
  assign in_entry_index  = s_axis_tdata[9:0];
  assign in_address      = s_axis_tdata[41:10];
  assign in_range_length = s_axis_tdata[73:42];

  // State
  state_e state_q, state_d;

  logic [FCW-1:0]         f_used_q;
  logic [CCW-1:0]         c_used_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [FCW-1:0]         lo_q;
  logic [FCW-1:0]         hb_q;      // exclusive upper bound
  logic [FIW-1:0]         mid_q;
  logic [CCW-1:0]         k_q;
  logic [CIW-1:0]         cidx_q;
  logic                   rd_v_q;
  logic [COUNT_W-1:0]     undef_q;
  logic [HIT_CLASS_W-1:0] res_class_q;
  logic [HIT_INDEX_W-1:0] res_idx_q;
  logic [COUNT_W-1:0]     res_total_q;
  logic                   m_valid_q;
  logic [HIT_CLASS_W-1:0] m_class_q;
  logic [HIT_INDEX_W-1:0] m_idx_q;
  logic [COUNT_W-1:0]     m_total_q;

  // Table ports
  tbl_req_t           f_req, c_req;
  logic [ADDR_W-1:0]  f_start, f_len, c_start, c_len;
  logic [COUNT_W-1:0] f_hits, c_hits;

  // Control
  logic           in_acc;
  logic           f_more, c_more;
  logic           f_hit, c_hit, undef_hit;
  logic           out_load;
  logic [FCW:0]   mid_sum;
  logic [FCW-1:0] mid_c;

  // Shared range compare unit
  logic              cmp_coarse;
  logic [ADDR_W-1:0] cmp_start, cmp_len, cmp_diff;
  logic              cmp_in, cmp_below;

  assign cmp_coarse = (state_q == ST_CSCAN);
  assign cmp_start  = cmp_coarse ? c_start : f_start;
  assign cmp_len    = cmp_coarse ? c_len : f_len;
  assign cmp_diff   = addr_q - cmp_start;
  assign cmp_in     = (cmp_diff < cmp_len);
  assign cmp_below  = (cmp_start < addr_q);

  // Binary search midpoint
  assign mid_sum = (FCW+1)'(lo_q) + (FCW+1)'(hb_q) - (FCW+1)'(1);
  assign mid_c   = mid_sum[FCW:1];

  assign f_more = (lo_q < hb_q);
  assign c_more = (k_q < c_used_q);

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    in_acc        = s_axis_tvalid && s_axis_tready;
    f_hit         = (state_q == ST_FCHECK) && cmp_in;
    c_hit         = (state_q == ST_CSCAN) && rd_v_q && cmp_in;
    undef_hit     = (state_q == ST_CSCAN) && !rd_v_q && !c_more;
    out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

    f_req.load = in_acc && (in_kind == KIND_FINE) &&
                 (32'(in_entry_index) < 32'(FINE_DEPTH));
    f_req.rd   = (state_q == ST_FPROBE) && f_more;
    f_req.bump = f_hit;

    c_req.load = in_acc && (in_kind == KIND_COARSE) &&
                 (32'(in_entry_index) < 32'(COARSE_DEPTH));
    c_req.rd   = (state_q == ST_CSCAN) && !c_hit && c_more;
    c_req.bump = c_hit;
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_SAMPLE)) state_d = ST_FPROBE;
      end
      ST_FPROBE: begin
        state_d = f_more ? ST_FCHECK : ST_CSCAN;
      end
      ST_FCHECK: begin
        state_d = f_hit ? ST_OUT : ST_FPROBE;
      end
      ST_CSCAN: begin
        if (c_hit || undef_hit) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      f_used_q  <= '0;
      c_used_q  <= '0;
      undef_q   <= '0;
      rd_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes, counts saturated to the table depth
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FINE_USED) begin
          if (32'(cfg_data_i[FINE_USED_W-1:0]) > 32'(FINE_DEPTH)) begin
            f_used_q <= FCW'(FINE_DEPTH);
          end else begin
            f_used_q <= FCW'(cfg_data_i[FINE_USED_W-1:0]);
          end
        end else if (cfg_index_i == CFG_COARSE_USED) begin
          if (32'(cfg_data_i[COARSE_USED_W-1:0]) > 32'(COARSE_DEPTH)) begin
            c_used_q <= CCW'(COARSE_DEPTH);
          end else begin
            c_used_q <= CCW'(cfg_data_i[COARSE_USED_W-1:0]);
          end
        end
      end

      if (undef_hit) undef_q <= undef_q + COUNT_W'(1);

      if (state_q == ST_FPROBE) begin
        rd_v_q <= 1'b0;
      end else if (state_q == ST_CSCAN) begin
        rd_v_q <= c_req.rd;
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_kind == KIND_SAMPLE)) begin
      addr_q <= in_address;
      lo_q   <= '0;
      hb_q   <= f_used_q;
    end
    if (f_req.rd) mid_q <= FIW'(mid_c);
    if ((state_q == ST_FPROBE) && !f_more) k_q <= '0;
    if ((state_q == ST_FCHECK) && !cmp_in) begin
      if (cmp_below) begin
        lo_q <= FCW'(mid_q) + FCW'(1);
      end else begin
        hb_q <= FCW'(mid_q);
      end
    end
    if (c_req.rd) begin
      k_q    <= k_q + CCW'(1);
      cidx_q <= CIW'(k_q);
    end

    // result capture
    if (f_hit) begin
      res_class_q <= CLS_FINE;
      res_idx_q   <= HIT_INDEX_W'(mid_q);
      res_total_q <= f_hits + COUNT_W'(1);
    end else if (c_hit) begin
      res_class_q <= CLS_COARSE;
      res_idx_q   <= HIT_INDEX_W'(cidx_q);
      res_total_q <= c_hits + COUNT_W'(1);
    end else if (undef_hit) begin
      res_class_q <= CLS_UNDEF;
      res_idx_q   <= '0;
      res_total_q <= undef_q + COUNT_W'(1);
    end

    // output register
    if (out_load) begin
      m_class_q <= res_class_q;
      m_idx_q   <= res_idx_q;
      m_total_q <= res_total_q;
    end
  end

  // Range tables
  arh_range_table #(
    .DEPTH (FINE_DEPTH),
    .IW    (FIW)
  ) u_fine (
    .clk_i        (clk_i),
    .req_i        (f_req),
    .ld_idx_i     (FIW'(in_entry_index)),
    .ld_start_i   (in_address),
    .ld_len_i     (in_range_length),
    .rd_idx_i     (FIW'(mid_c)),
    .bump_idx_i   (mid_q),
    .bump_total_i (f_hits + COUNT_W'(1)),
    .rd_start_o   (f_start),
    .rd_len_o     (f_len),
    .rd_hits_o    (f_hits)
  );

  arh_range_table #(
    .DEPTH (COARSE_DEPTH),
    .IW    (CIW)
  ) u_coarse (
    .clk_i        (clk_i),
    .req_i        (c_req),
    .ld_idx_i     (CIW'(in_entry_index)),
    .ld_start_i   (in_address),
    .ld_len_i     (in_range_length),
    .rd_idx_i     (CIW'(k_q)),
    .bump_idx_i   (cidx_q),
    .bump_total_i (c_hits + COUNT_W'(1)),
    .rd_start_o   (c_start),
    .rd_len_o     (c_len),
    .rd_hits_o    (c_hits)
  );

  // Ports
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_class_q;
  assign m_axis_tdata  = {6'b0, m_total_q, m_idx_q};

endmodule

// ===== rtl/core/arh_range_table.sv =====
`timescale 1ns / 1ps

module arh_range_table #(
  parameter int unsigned DEPTH = arh_pkg::FINE_DEPTH_DEF,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  arh_pkg::tbl_req_t           req_i,
  input  logic [IW-1:0]               ld_idx_i,
  input  logic [arh_pkg::ADDR_W-1:0]  ld_start_i,
  input  logic [arh_pkg::ADDR_W-1:0]  ld_len_i,
  input  logic [IW-1:0]               rd_idx_i,
  input  logic [IW-1:0]               bump_idx_i,
  input  logic [arh_pkg::COUNT_W-1:0] bump_total_i,
  output logic [arh_pkg::ADDR_W-1:0]  rd_start_o,
  output logic [arh_pkg::ADDR_W-1:0]  rd_len_o,
  output logic [arh_pkg::COUNT_W-1:0] rd_hits_o
);
  import arh_pkg::*;

  logic [ADDR_W-1:0]  start_mem [DEPTH];
  logic [ADDR_W-1:0]  len_mem   [DEPTH];
  logic [COUNT_W-1:0] hits_mem  [DEPTH];

  // Range entry write (loads only)
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      start_mem[ld_idx_i] <= ld_start_i;
      len_mem[ld_idx_i]   <= ld_len_i;
    end
  end

  // Counter write: cleared on load, incremented on hit
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      hits_mem[ld_idx_i] <= '0;
    end else if (req_i.bump) begin
      hits_mem[bump_idx_i] <= bump_total_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_start_o <= start_mem[rd_idx_i];
      rd_len_o   <= len_mem[rd_idx_i];
      rd_hits_o  <= hits_mem[rd_idx_i];
    end
  end

endmodule
